// File: design/planar_bitmap_rle_decoder_unit_defines.svh
`ifndef PLANAR_BITMAP_RLE_DECODER_UNIT_DEFINES_SVH
`define PLANAR_BITMAP_RLE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PBRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PBRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pbrd_pkg.sv
package pbrd_pkg;

    typedef enum logic [2:0] {
        ST_HDR_OK     = 3'd0,
        ST_RUN        = 3'd1,
        ST_BAD_LAYOUT = 3'd2,
        ST_ZERO_LIT   = 3'd3,
        ST_ZERO_RUN   = 3'd4,
        ST_TRUNC      = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_CTRL   = 4'd1,
        PH_LIT_HI = 4'd2,
        PH_LIT_LO = 4'd3,
        PH_REP    = 4'd4,
        PH_CNT_LO = 4'd5,
        PH_SW0    = 4'd6,
        PH_SW1    = 4'd7,
        PH_TRAIL  = 4'd8,
        PH_DRAIN  = 4'd9
    } t_phase;

    // Top two bits of a control byte.
    typedef enum logic [1:0] {
        CK_LITERAL = 2'b00,
        CK_REPEAT  = 2'b01,
        CK_LONG    = 2'b10,
        CK_SWAP    = 2'b11
    } t_ctrl_kind;

    localparam logic [7:0]  SEQ_HIGH_BYTE = 8'h80;
    localparam logic [15:0] SEQ_MIN_HEIGHT = 16'd200;
    localparam logic [7:0]  HEIGHT_LIMIT  = 8'd200;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] word_value;
        logic [13:0] run_length;
        logic [13:0] word_position;
        logic        image_done;
        logic [8:0]  pixel_width;
        logic [7:0]  pixel_height;
        logic        seq_layout;
    } t_out_item;

    // Request from the parser to the output side.
    typedef struct packed {
        t_status     status;
        logic [15:0] word_value;
        logic [13:0] run_length;
        logic [13:0] word_position;
        logic        image_done;
        logic        hdr_valid;
        logic [6:0]  row_words_lo;
        logic [7:0]  height;
        logic        seq;
    } t_req;

    typedef struct packed {
        logic at_header;
        logic hdr_valid;
    } t_front_stat;

endpackage

// File: design/pbrd_front.sv
module pbrd_front #(
    parameter int MAX_ROW_WORDS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pbrd_pkg::t_in_item i_in_item,
    input  logic               i_q_full,
    output logic               o_push,
    output pbrd_pkg::t_req     o_req,
    output pbrd_pkg::t_front_stat o_stat
);

    localparam int RW_W  = $clog2(MAX_ROW_WORDS + 1);
    localparam int TOT_W = $clog2(MAX_ROW_WORDS * 199 + 1);
    localparam int CMP_W = (TOT_W > 14) ? TOT_W : 14;
    localparam int PRD_W = RW_W + 8;

    pbrd_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_hdr_cnt, n_hdr_cnt;
    logic [15:0]      r_row_words, n_row_words;
    logic [15:0]      r_height_word, n_height_word;
    logic             r_seq, n_seq;
    logic             r_hdr_valid, n_hdr_valid;
    logic [TOT_W-1:0] r_words_done, n_words_done;
    logic [TOT_W-1:0] r_words_total, n_words_total;
    logic [13:0]      r_run_count, n_run_count;
    logic [5:0]       r_lit_left, n_lit_left;
    logic [7:0]       r_held, n_held;

    logic             accept;
    logic [7:0]       b;
    logic             last;

    // run clipping
    logic [13:0]      e_cnt;
    logic [TOT_W-1:0] e_rem;
    logic [TOT_W-1:0] e_len;
    logic [TOT_W-1:0] e_new;
    logic             e_fin;

    // header check
    logic [15:0]      hw;
    logic             hw_seq;
    logic [7:0]       hw_h;
    logic             hdr_bad;
    logic [PRD_W-1:0] prod;

    logic             emit;
    pbrd_pkg::t_status st;
    logic [15:0]      q_val;
    logic             q_run;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_item.data_byte;
    assign last       = i_in_item.record_end;
    assign o_push     = accept && emit;

    assign o_stat.at_header = (r_phase == pbrd_pkg::PH_HDR) && (r_hdr_cnt == 2'd0);
    assign o_stat.hdr_valid = r_hdr_valid;

    always_comb begin
        e_cnt = (r_phase == pbrd_pkg::PH_LIT_LO) ? 14'd1 : r_run_count;
        e_rem = r_words_total - r_words_done;
        e_len = (CMP_W'(e_cnt) < CMP_W'(e_rem)) ? TOT_W'(e_cnt) : e_rem;
        e_new = r_words_done + e_len;
        e_fin = (e_new >= r_words_total);

        hw      = {r_height_word[7:0], b};
        hw_seq  = (hw >= pbrd_pkg::SEQ_MIN_HEIGHT);
        hw_h    = hw[7:0];
        hdr_bad = (r_row_words == 16'd0)
               || ({16'd0, r_row_words} > 32'(MAX_ROW_WORDS))
               || (r_row_words[1:0] != 2'b00)
               || (hw_h == 8'd0)
               || (hw_h >= pbrd_pkg::HEIGHT_LIMIT)
               || (hw_seq && (hw[15:8] != pbrd_pkg::SEQ_HIGH_BYTE));
        prod    = PRD_W'(r_row_words[RW_W-1:0]) * PRD_W'(hw_h);
    end

    always_comb begin
        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_row_words   = r_row_words;
        n_height_word = r_height_word;
        n_seq         = r_seq;
        n_hdr_valid   = r_hdr_valid;
        n_words_done  = r_words_done;
        n_words_total = r_words_total;
        n_run_count   = r_run_count;
        n_lit_left    = r_lit_left;
        n_held        = r_held;
        emit          = 1'b0;
        st            = pbrd_pkg::ST_RUN;
        q_val         = 16'd0;
        q_run         = 1'b0;

        unique case (r_phase)
            pbrd_pkg::PH_HDR: begin
                if (r_hdr_cnt[1] == 1'b0) begin
                    n_row_words = {r_row_words[7:0], b};
                end else begin
                    n_height_word = hw;
                end
                n_hdr_cnt = r_hdr_cnt + 2'd1;
                if (r_hdr_cnt == 2'd3) begin
                    emit = 1'b1;
                    if (hdr_bad) begin
                        st      = pbrd_pkg::ST_BAD_LAYOUT;
                        n_phase = pbrd_pkg::PH_DRAIN;
                    end else begin
                        st            = pbrd_pkg::ST_HDR_OK;
                        n_hdr_valid   = 1'b1;
                        n_seq         = hw_seq;
                        n_height_word = {8'd0, hw_h};
                        n_words_total = TOT_W'(prod);
                        n_words_done  = '0;
                        n_phase       = pbrd_pkg::PH_CTRL;
                    end
                end
            end
            pbrd_pkg::PH_CTRL: begin
                n_run_count = {8'd0, b[5:0]};
                unique case (pbrd_pkg::t_ctrl_kind'(b[7:6]))
                    pbrd_pkg::CK_LITERAL: begin
                        if (b == 8'd0) begin
                            emit    = 1'b1;
                            st      = pbrd_pkg::ST_ZERO_LIT;
                            n_phase = pbrd_pkg::PH_DRAIN;
                        end else begin
                            n_lit_left = (CMP_W'(b[5:0]) < CMP_W'(e_rem)) ? b[5:0] : 6'(e_rem);
                            n_phase    = pbrd_pkg::PH_LIT_HI;
                        end
                    end
                    pbrd_pkg::CK_REPEAT: n_phase = pbrd_pkg::PH_REP;
                    pbrd_pkg::CK_LONG:   n_phase = pbrd_pkg::PH_CNT_LO;
                    pbrd_pkg::CK_SWAP:   n_phase = pbrd_pkg::PH_SW0;
                    default:             n_phase = pbrd_pkg::PH_SW0;
                endcase
            end
            pbrd_pkg::PH_LIT_HI: begin
                n_held  = b;
                n_phase = pbrd_pkg::PH_LIT_LO;
            end
            pbrd_pkg::PH_LIT_LO: begin
                emit         = 1'b1;
                q_run        = 1'b1;
                q_val        = {r_held, b};
                n_words_done = e_new;
                n_lit_left   = (r_lit_left != 6'd0) ? (r_lit_left - 6'd1) : 6'd0;
                if (e_fin) begin
                    n_phase = pbrd_pkg::PH_TRAIL;
                end else if (n_lit_left != 6'd0) begin
                    n_phase = pbrd_pkg::PH_LIT_HI;
                end else begin
                    n_phase = pbrd_pkg::PH_CTRL;
                end
            end
            pbrd_pkg::PH_REP: begin
                emit = 1'b1;
                if (r_run_count == 14'd0) begin
                    st      = pbrd_pkg::ST_ZERO_RUN;
                    n_phase = pbrd_pkg::PH_DRAIN;
                end else begin
                    q_run        = 1'b1;
                    q_val        = {b, b};
                    n_words_done = e_new;
                    n_phase      = e_fin ? pbrd_pkg::PH_TRAIL : pbrd_pkg::PH_CTRL;
                end
            end
            pbrd_pkg::PH_CNT_LO: begin
                n_run_count = {r_run_count[5:0], b};
                n_phase     = pbrd_pkg::PH_SW0;
            end
            pbrd_pkg::PH_SW0: begin
                n_held  = b;
                n_phase = pbrd_pkg::PH_SW1;
            end
            pbrd_pkg::PH_SW1: begin
                emit = 1'b1;
                if (r_run_count == 14'd0) begin
                    st      = pbrd_pkg::ST_ZERO_RUN;
                    n_phase = pbrd_pkg::PH_DRAIN;
                end else begin
                    q_run        = 1'b1;
                    q_val        = {b, r_held};
                    n_words_done = e_new;
                    n_phase      = e_fin ? pbrd_pkg::PH_TRAIL : pbrd_pkg::PH_CTRL;
                end
            end
            default: begin
                // trailing bytes and error drain: nothing to do
            end
        endcase

        o_req.status        = st;
        o_req.word_value    = q_run ? q_val : 16'd0;
        o_req.run_length    = q_run ? 14'(e_len) : 14'd0;
        o_req.word_position = q_run ? 14'(r_words_done) : 14'd0;
        o_req.image_done    = q_run && e_fin;
        o_req.hdr_valid     = n_hdr_valid;
        o_req.row_words_lo  = n_row_words[6:0];
        o_req.height        = n_height_word[7:0];
        o_req.seq           = n_seq;

        // record cut short: keeps a completed run's fields, never done
        if (last && (n_phase != pbrd_pkg::PH_TRAIL) && (n_phase != pbrd_pkg::PH_DRAIN)) begin
            emit             = 1'b1;
            o_req.status     = pbrd_pkg::ST_TRUNC;
            o_req.image_done = 1'b0;
        end

        if (last) begin
            n_phase       = pbrd_pkg::PH_HDR;
            n_hdr_cnt     = 2'd0;
            n_row_words   = 16'd0;
            n_height_word = 16'd0;
            n_seq         = 1'b0;
            n_hdr_valid   = 1'b0;
            n_words_done  = '0;
            n_words_total = '0;
            n_run_count   = 14'd0;
            n_lit_left    = 6'd0;
            n_held        = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pbrd_pkg::PH_HDR;
            r_hdr_cnt     <= 2'd0;
            r_row_words   <= 16'd0;
            r_height_word <= 16'd0;
            r_seq         <= 1'b0;
            r_hdr_valid   <= 1'b0;
            r_words_done  <= '0;
            r_words_total <= '0;
            r_run_count   <= 14'd0;
            r_lit_left    <= 6'd0;
            r_held        <= 8'd0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_hdr_cnt     <= n_hdr_cnt;
            r_row_words   <= n_row_words;
            r_height_word <= n_height_word;
            r_seq         <= n_seq;
            r_hdr_valid   <= n_hdr_valid;
            r_words_done  <= n_words_done;
            r_words_total <= n_words_total;
            r_run_count   <= n_run_count;
            r_lit_left    <= n_lit_left;
            r_held        <= n_held;
        end
    end

endmodule

// File: design/pbrd_queue.sv
module pbrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbrd_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    output pbrd_pkg::t_req o_req,
    input  logic           i_pop
);

    pbrd_pkg::t_req r_mem [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

// File: design/pbrd_back.sv
module pbrd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  pbrd_pkg::t_req      i_req,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbrd_pkg::t_out_item o_out_item
);

    logic                r_valid;
    pbrd_pkg::t_out_item r_item, n_item;

    assign o_pop       = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    // header dimensions read as zero until a header has been accepted
    always_comb begin
        n_item.status        = i_req.status;
        n_item.word_value    = i_req.word_value;
        n_item.run_length    = i_req.run_length;
        n_item.word_position = i_req.word_position;
        n_item.image_done    = i_req.image_done;
        n_item.pixel_width   = i_req.hdr_valid ? {i_req.row_words_lo, 2'b00} : 9'd0;
        n_item.pixel_height  = i_req.hdr_valid ? i_req.height : 8'd0;
        n_item.seq_layout    = i_req.hdr_valid && i_req.seq;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: design/planar_bitmap_rle_decoder_unit.sv
// Channel   Valid        Ready        Payload (pbrd_pkg)
// bytes in  i_in_valid   o_in_ready   i_in_item  : t_in_item  (data_byte, record_end)
// results   o_out_valid  i_out_ready  o_out_item : t_out_item (status .. seq_layout)
//
// One byte per cycle unless the queue is full; parser state is registered per byte.
// A result enters the queue at the edge that takes its byte, then reaches o_out_valid
// through the output register once popped; other bytes only advance the parser.
// Reset is synchronous, active low; no memory, so no clearing pass.
// A two-request queue between parser and output register absorbs output stalls;
// o_in_ready drops only once that queue is full.
`include "planar_bitmap_rle_decoder_unit_defines.svh"

module planar_bitmap_rle_decoder_unit #(
    parameter int MAX_ROW_WORDS = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pbrd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbrd_pkg::t_out_item o_out_item
);

    // parser -> queue
    logic                  w_push;
    pbrd_pkg::t_req        w_push_req;
    logic                  w_q_full;
    pbrd_pkg::t_front_stat w_stat;

    // queue -> output stage
    logic                  w_q_valid;
    pbrd_pkg::t_req        w_q_req;
    logic                  w_pop;

    // assertion terms
    logic                  w_out_run;
    logic                  w_out_hdr;
    logic                  w_out_done;
    logic                  w_in_last;
    logic                  w_rearmed;

    // Front: header assembly and check, control byte decode, run clipping
    // against the words left in the image, truncation on record_end.
    pbrd_front #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_req      (w_push_req),
        .o_stat     (w_stat)
    );

    // Short request queue so parser and consumer stall independently.
    pbrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_req   (w_q_req),
        .i_pop   (w_pop)
    );

    // Back: formats each request into a result and holds it until taken.
    pbrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_req       (w_q_req),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Assertions
    assign w_out_run  = o_out_valid && (o_out_item.status == pbrd_pkg::ST_RUN);
    assign w_out_hdr  = o_out_valid && (o_out_item.status == pbrd_pkg::ST_HDR_OK);
    assign w_out_done = o_out_valid && o_out_item.image_done;
    assign w_in_last  = i_in_valid && o_in_ready && i_in_item.record_end;
    assign w_rearmed  = w_stat.at_header && !w_stat.hdr_valid;

    `PBRD_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_q_full, "push when full")
    `PBRD_ASSERT_IMP(a_done_only_on_run, i_clk, i_rst_n, w_out_done, w_out_run, "done off run")
    `PBRD_ASSERT_IMP(a_run_not_empty, i_clk, i_rst_n, w_out_run, o_out_item.run_length != 14'd0, "empty run")
    `PBRD_ASSERT_IMP(a_hdr_height, i_clk, i_rst_n, w_out_hdr, o_out_item.pixel_height != 8'd0, "zero height")
    `PBRD_ASSERT_NXT(a_rearm, i_clk, i_rst_n, w_in_last, w_rearmed, "no rearm after record end")

endmodule
